FILE: rtl/serial_command_frame_parser_core_assert.svh
// ----------------------------------------------------------------------------
// serial command frame parser assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define SFP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types, constants and microcode encoding of the frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

  // default sizing
  localparam int FRAME_BYTES_DEF = 50;
  localparam int FIELD_COUNT_DEF = 13;
  localparam int FIELD_CHARS_DEF = 10;

  // characters and values
  localparam logic [7:0]  CH_TERM      = 8'h23;
  localparam logic [7:0]  CH_COMMA     = 8'h2c;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  CH_TAB       = 8'h09;
  localparam logic [7:0]  CH_CR        = 8'h0d;
  localparam logic [7:0]  CH_PLUS      = 8'h2b;
  localparam logic [7:0]  CH_MINUS     = 8'h2d;
  localparam logic [7:0]  CH_ZERO      = 8'h30;
  localparam logic [7:0]  CH_NINE      = 8'h39;
  localparam logic [15:0] STORE_MARKER = 16'd6969;
  localparam int          STORE_MAX    = 12;

  // command codes in field 0
  localparam logic [15:0] CMD_OFF   = 16'd1;
  localparam logic [15:0] CMD_ON    = 16'd2;
  localparam logic [15:0] CMD_STORE = 16'd3;
  localparam logic [15:0] CMD_SETPT = 16'd4;

  typedef enum logic [2:0] {
    ACT_OFF     = 3'd0,
    ACT_ON      = 3'd1,
    ACT_STORE   = 3'd2,
    ACT_RESET   = 3'd3,
    ACT_SETPT   = 3'd4,
    ACT_UNKNOWN = 3'd5,
    ACT_DONE    = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    PH_BLANKS  = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  // microcode fields
  typedef enum logic {
    ADDR_ZERO = 1'b0,
    ADDR_K2   = 1'b1
  } addr_sel_t;

  typedef enum logic [1:0] {
    DATA_ZERO   = 2'd0,
    DATA_STORE  = 2'd1,
    DATA_MARKER = 2'd2
  } data_sel_t;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_GOTO     = 3'd1,
    J_DISPATCH = 3'd2,
    J_LOOP     = 3'd3,
    J_END      = 3'd4
  } jump_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    action_t   act;
    addr_sel_t asel;
    data_sel_t dsel;
    logic      emit;
    logic      last;
    jump_t     jmp;
    upc_t      target;
  } uword_t;

  // program step labels
  localparam upc_t S_DISPATCH = 4'd0;
  localparam upc_t S_OFF      = 4'd1;
  localparam upc_t S_ON       = 4'd2;
  localparam upc_t S_STORE    = 4'd3;
  localparam upc_t S_MARKER   = 4'd4;
  localparam upc_t S_RESET    = 4'd5;
  localparam upc_t S_SETPT    = 4'd6;
  localparam upc_t S_UNKNOWN  = 4'd7;
  localparam upc_t S_DONE     = 4'd8;

  // parser status seen by the sequencer
  typedef struct packed {
    logic [15:0] cmd;
    logic        ovf;
    logic [15:0] rd_data;
  } pstat_t;

endpackage

FILE: rtl/serial_command_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_parser_core
// command frame parser: splits received bytes into numeric fields and
// dispatches the command at the frame terminator
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one received character per beat in in_tdata.
//   out_* : one action per beat; kind in out_tuser, address and value in
//           out_tdata, out_tlast on the frame done beat.
//   An ordinary byte is taken and the next may follow at once.
//   A '#' byte starts the dispatch program in the control store: one step
//   to pick the command, then one step per result (store command: 12 words,
//   marker, reset request, done).
//   in_tready is low while that program runs; results follow one per cycle
//   while out_tready stays high, each through the output register.
//   A stalled receiver holds the current step; the program waits for the
//   output register to free up and nothing is dropped.
//   The next byte is taken while the done beat still waits in the output
//   register.
//   Reset empties the frame, the field store and the output register.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_core
  import sfp_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int FIELD_COUNT = FIELD_COUNT_DEF,
  parameter int FIELD_CHARS = FIELD_CHARS_DEF
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [4:0] store_address, [20:5] data_value, [23:21] zero
  output logic [2:0]  out_tuser,  // [2:0] action
  output logic        out_tlast
);

  localparam int IDX_W = $clog2(FIELD_COUNT);

  logic             in_acc;
  logic             is_term;
  logic             frame_clr;
  logic [IDX_W-1:0] rd_idx;
  logic             busy;
  pstat_t           stat;
  action_t          out_act;
  logic [4:0]       out_addr;
  logic [15:0]      out_data;

  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;
  assign is_term   = (in_tdata == CH_TERM);

  // byte parsing and field store
  sfp_field_conv #(
    .FRAME_BYTES (FRAME_BYTES),
    .FIELD_COUNT (FIELD_COUNT),
    .FIELD_CHARS (FIELD_CHARS)
  ) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (in_acc),
    .byte_in   (in_tdata),
    .frame_clr (frame_clr),
    .rd_idx    (rd_idx),
    .stat      (stat)
  );

  // dispatch program
  sfp_sequencer #(
    .FIELD_COUNT (FIELD_COUNT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && is_term),
    .stat      (stat),
    .frame_clr (frame_clr),
    .rd_idx    (rd_idx),
    .busy      (busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_act   (out_act),
    .out_addr  (out_addr),
    .out_data  (out_data),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, out_data, out_addr};
  assign out_tuser = out_act;

  // checks
`include "serial_command_frame_parser_core_assert.svh"

  `SFP_ASSERT_NEXT(a_term_starts, in_tvalid && in_tready && in_tdata == CH_TERM, busy, "terminator did not start dispatch")
  `SFP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output beat changed while stalled")
  `SFP_ASSERT_SAME(a_last_kind, out_tvalid && out_tlast, out_tuser == ACT_DONE, "last beat is not frame done")

endmodule

FILE: rtl/sfp_ucode_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_ucode_rom
// control store of the dispatch program, one control word per step
// ----------------------------------------------------------------------------
module sfp_ucode_rom
  import sfp_pkg::*;
(
  input  upc_t   upc,
  output uword_t uword
);

  // program: dispatch, one emit step for off, on, setpoint and unknown, store loop with marker and reset, done
  always_comb begin
    unique case (upc)
      S_DISPATCH: uword = '{ACT_DONE,    ADDR_ZERO, DATA_ZERO,   1'b0, 1'b0, J_DISPATCH, S_DONE};
      S_OFF:      uword = '{ACT_OFF,     ADDR_ZERO, DATA_ZERO,   1'b1, 1'b0, J_GOTO,     S_DONE};
      S_ON:       uword = '{ACT_ON,      ADDR_ZERO, DATA_ZERO,   1'b1, 1'b0, J_GOTO,     S_DONE};
      S_STORE:    uword = '{ACT_STORE,   ADDR_K2,   DATA_STORE,  1'b1, 1'b0, J_LOOP,     S_MARKER};
      S_MARKER:   uword = '{ACT_STORE,   ADDR_ZERO, DATA_MARKER, 1'b1, 1'b0, J_NEXT,     S_RESET};
      S_RESET:    uword = '{ACT_RESET,   ADDR_ZERO, DATA_ZERO,   1'b1, 1'b0, J_GOTO,     S_DONE};
      S_SETPT:    uword = '{ACT_SETPT,   ADDR_ZERO, DATA_STORE,  1'b1, 1'b0, J_GOTO,     S_DONE};
      S_UNKNOWN:  uword = '{ACT_UNKNOWN, ADDR_ZERO, DATA_ZERO,   1'b1, 1'b0, J_GOTO,     S_DONE};
      S_DONE:     uword = '{ACT_DONE,    ADDR_ZERO, DATA_ZERO,   1'b1, 1'b1, J_END,      S_DONE};
      default:    uword = '{ACT_DONE,    ADDR_ZERO, DATA_ZERO,   1'b1, 1'b1, J_END,      S_DONE};
    endcase
  end

endmodule

FILE: rtl/sfp_field_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_field_conv
// per-byte frame tracking, comma splitting, atoi-style conversion and the
// field store with per-entry valid bits
// ----------------------------------------------------------------------------
module sfp_field_conv
  import sfp_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int FIELD_COUNT = FIELD_COUNT_DEF,
  parameter int FIELD_CHARS = FIELD_CHARS_DEF,
  localparam int IDX_W      = $clog2(FIELD_COUNT)
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_acc,
  input  logic [7:0]       byte_in,
  input  logic             frame_clr,
  input  logic [IDX_W-1:0] rd_idx,
  output pstat_t           stat
);

  localparam int LEN_W = $clog2(FRAME_BYTES);
  localparam int FN_W  = $clog2(FIELD_COUNT + 1);
  localparam int CH_W  = $clog2(FIELD_CHARS);

  logic [LEN_W-1:0]   frame_len_r, frame_len_nxt;
  logic [FN_W-1:0]    field_num_r, field_num_nxt;
  logic [CH_W-1:0]    chars_r, chars_nxt;
  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [15:0]        acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic [15:0]        store_r [FIELD_COUNT];
  logic [FIELD_COUNT-1:0] vld_r, vld_nxt;

  logic               commit;
  logic [15:0]        commit_val;
  logic               fn_in_range;
  logic               is_blank, is_digit;
  logic [15:0]        acc_x10;

  assign fn_in_range = (field_num_r < FN_W'(FIELD_COUNT));
  assign commit_val  = neg_r ? 16'(16'd0 - acc_r) : acc_r;
  assign is_blank    = (byte_in == CH_SPACE) || (byte_in >= CH_TAB && byte_in <= CH_CR);
  assign is_digit    = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign acc_x10     = 16'({acc_r, 3'b000} + {acc_r, 1'b0});

  // frame, field and conversion state
  always_comb begin
    frame_len_nxt = frame_len_r;
    field_num_nxt = field_num_r;
    chars_nxt     = chars_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    vld_nxt       = vld_r;
    commit        = 1'b0;
    if (frame_clr) begin
      frame_len_nxt = '0;
      field_num_nxt = '0;
      chars_nxt     = '0;
      phase_nxt     = PH_BLANKS;
      neg_nxt       = 1'b0;
      acc_nxt       = '0;
      ovf_nxt       = 1'b0;
      vld_nxt       = '0;
    end else if (byte_acc) begin
      priority if (byte_in == CH_TERM) begin
        commit = (frame_len_r != '0) && fn_in_range;
      end else if (frame_len_r >= LEN_W'(FRAME_BYTES - 1)) begin
        ovf_nxt = 1'b1;
      end else begin
        frame_len_nxt = frame_len_r + 1'b1;
        if (frame_len_r != '0) begin
          if (byte_in == CH_COMMA) begin
            commit    = fn_in_range;
            if (fn_in_range) field_num_nxt = field_num_r + 1'b1;
            chars_nxt = '0;
            phase_nxt = PH_BLANKS;
            neg_nxt   = 1'b0;
            acc_nxt   = '0;
          end else if (fn_in_range && chars_r < CH_W'(FIELD_CHARS - 1)) begin
            chars_nxt = chars_r + 1'b1;
            // blank skip, sign, then digits until the first other char
            unique case (phase_r)
              PH_BLANKS: begin
                priority if (is_blank) begin
                  phase_nxt = PH_BLANKS;
                end else if (byte_in == CH_PLUS || byte_in == CH_MINUS) begin
                  neg_nxt   = (byte_in == CH_MINUS);
                  phase_nxt = PH_DIGITS;
                end else if (is_digit) begin
                  phase_nxt = PH_DIGITS;
                  acc_nxt   = 16'(acc_x10 + 16'(byte_in - CH_ZERO));
                end else begin
                  phase_nxt = PH_STOPPED;
                end
              end
              PH_DIGITS: begin
                if (is_digit) begin
                  acc_nxt = 16'(acc_x10 + 16'(byte_in - CH_ZERO));
                end else begin
                  phase_nxt = PH_STOPPED;
                end
              end
              default: phase_nxt = phase_r;
            endcase
          end
        end
      end
    end
    if (commit) vld_nxt[field_num_r[IDX_W-1:0]] = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= '0;
      field_num_r <= '0;
      chars_r     <= '0;
      phase_r     <= PH_BLANKS;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      vld_r       <= '0;
    end else begin
      frame_len_r <= frame_len_nxt;
      field_num_r <= field_num_nxt;
      chars_r     <= chars_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      vld_r       <= vld_nxt;
    end
  end

  // field store payload, an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (commit) store_r[field_num_r[IDX_W-1:0]] <= commit_val;
  end

  assign stat.cmd     = vld_r[0] ? store_r[0] : 16'd0;
  assign stat.ovf     = ovf_r;
  assign stat.rd_data = vld_r[rd_idx] ? store_r[rd_idx] : 16'd0;

endmodule

FILE: rtl/sfp_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_sequencer
// step counter, store index and output register driven by the control store
// ----------------------------------------------------------------------------
module sfp_sequencer
  import sfp_pkg::*;
#(
  parameter int FIELD_COUNT = FIELD_COUNT_DEF,
  localparam int IDX_W      = $clog2(FIELD_COUNT)
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  pstat_t           stat,
  output logic             frame_clr,
  output logic [IDX_W-1:0] rd_idx,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output action_t          out_act,
  output logic [4:0]       out_addr,
  output logic [15:0]      out_data,
  output logic             out_last
);

  localparam int LIM_I = (FIELD_COUNT - 1 < STORE_MAX) ? FIELD_COUNT - 1 : STORE_MAX;
  localparam logic [IDX_W-1:0] LIM = IDX_W'(LIM_I);

  logic             busy_r, busy_nxt;
  upc_t             upc_r, upc_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             ov_r, ov_nxt;
  action_t          act_r;
  logic [4:0]       addr_r;
  logic [15:0]      data_r;
  logic             last_r;

  uword_t           uw;
  logic             advance;
  logic             load;
  upc_t             disp_tgt;

  sfp_ucode_rom u_rom (
    .upc   (upc_r),
    .uword (uw)
  );

  assign advance = busy_r && (!uw.emit || !ov_r || out_ready);
  assign load    = advance && uw.emit;

  // command dispatch target
  always_comb begin
    priority if (stat.ovf)              disp_tgt = S_DONE;
    else if (stat.cmd == CMD_OFF)       disp_tgt = S_OFF;
    else if (stat.cmd == CMD_ON)        disp_tgt = S_ON;
    else if (stat.cmd == CMD_STORE)     disp_tgt = S_STORE;
    else if (stat.cmd == CMD_SETPT)     disp_tgt = S_SETPT;
    else                                disp_tgt = S_UNKNOWN;
  end

  // next step and store index
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    k_nxt    = k_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        upc_nxt  = S_DISPATCH;
      end
    end else if (advance) begin
      unique case (uw.jmp)
        J_NEXT:     upc_nxt = upc_r + 1'b1;
        J_GOTO:     upc_nxt = uw.target;
        J_DISPATCH: begin
          upc_nxt = disp_tgt;
          k_nxt   = IDX_W'(1);
        end
        J_LOOP: begin
          if (k_r == LIM) upc_nxt = uw.target;
          else            k_nxt   = k_r + 1'b1;
        end
        J_END:      busy_nxt = 1'b0;
        default:    busy_nxt = 1'b0;
      endcase
    end
  end

  // output beat holding register
  always_comb begin
    ov_nxt = ov_r;
    if (load)           ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= S_DISPATCH;
      k_r    <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      k_r    <= k_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // result payload selected by the control word
  always_ff @(posedge clk) begin
    if (load) begin
      act_r  <= uw.act;
      last_r <= uw.last;
      addr_r <= (uw.asel == ADDR_K2) ? 5'({k_r, 1'b0}) : 5'd0;
      unique case (uw.dsel)
        DATA_STORE:  data_r <= stat.rd_data;
        DATA_MARKER: data_r <= STORE_MARKER;
        default:     data_r <= 16'd0;
      endcase
    end
  end

  assign frame_clr = advance && (uw.jmp == J_END);
  assign rd_idx    = k_r;
  assign busy      = busy_r;
  assign out_valid = ov_r;
  assign out_act   = act_r;
  assign out_addr  = addr_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule

FILE: tb/serial_command_frame_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_frame_parser_core_tb
// self-checking bench: feeds serial characters, predicts every action beat
// from its own frame parser model or the directed table, compares all fields in order
// ----------------------------------------------------------------------------
module serial_command_frame_parser_core_tb;
  import sfp_pkg::*;

  localparam int FRM_BYTES  = FRAME_BYTES_DEF;
  localparam int FLD_COUNT  = FIELD_COUNT_DEF;
  localparam int FLD_CHARS  = FIELD_CHARS_DEF;
  localparam int RAND_BYTES = 470;
  localparam int QUIET_AT   = 380;
  localparam int DRAIN_WAIT = 32;
  localparam int STUCK_MAX  = 5000;

  // one action beat as the block should send it
  typedef struct packed {
    action_t     act;
    logic [4:0]  addr;
    logic [15:0] data;
    logic        last;
  } action_rec_t;

  // directed frame; typed rows carry the dispatched action read off directly
  typedef struct {
    string       txt;
    bit          typed;
    action_t     act;
    logic [15:0] val;
  } frame_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [4:0] store_address, [20:5] data_value
  logic [2:0]  out_tuser;         // [2:0] action
  logic        out_tlast;

  // parser state mirror
  int          rx_count;
  int          field_idx;
  int          field_chars;
  phase_t      conv_phase;
  logic        minus_seen;
  logic [15:0] digit_acc;
  logic [15:0] field_vals [FLD_COUNT];
  logic        frame_overflow;

  action_rec_t actions_due [$];
  logic [7:0]  frame_bytes [$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  beats_seen = 0;
  int  stores_seen = 0;
  int  frames_done = 0;
  int  overflow_frames = 0;
  int  stuck_cycles = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  bit  tx_gappy = 1'b0;
  bit  rx_gappy = 1'b1;

  frame_row_t dir_rows [6] = '{
    '{"#",          1'b1, ACT_UNKNOWN, 16'd0},
    '{",1#",        1'b1, ACT_OFF,     16'd0},
    '{"x2#",        1'b1, ACT_ON,      16'd0},
    '{"x4,-32768#", 1'b1, ACT_SETPT,   16'h8000},
    '{"x3#",        1'b0, ACT_DONE,    16'd0},
    '{"\3779\t#",   1'b1, ACT_UNKNOWN, 16'd0}
  };

  serial_command_frame_parser_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_frame();
    rx_count       = 0;
    field_idx      = 0;
    frame_overflow = 1'b0;
    field_chars    = 0;
    conv_phase     = PH_BLANKS;
    minus_seen     = 1'b0;
    digit_acc      = 16'd0;
    foreach (field_vals[i]) field_vals[i] = 16'd0;
  endfunction

  function automatic void due(action_t a, logic [4:0] ad, logic [15:0] d, logic l);
    action_rec_t r;
    r.act  = a;
    r.addr = ad;
    r.data = d;
    r.last = l;
    actions_due.push_back(r);
  endfunction

  function automatic void commit_field();
    logic [15:0] v;
    v = minus_seen ? 16'd0 - digit_acc : digit_acc;
    if (field_idx < FLD_COUNT) field_vals[field_idx] = v;
  endfunction

  // atoi-style conversion, only the first FLD_CHARS-1 characters count
  function automatic void convert_char(logic [7:0] c);
    if (field_idx >= FLD_COUNT || field_chars >= FLD_CHARS - 1) return;
    field_chars++;
    if (conv_phase == PH_BLANKS) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      if (c == CH_MINUS || c == CH_PLUS) begin
        minus_seen = (c == CH_MINUS);
        conv_phase = PH_DIGITS;
        return;
      end
      conv_phase = PH_DIGITS;
    end
    if (conv_phase == PH_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE)
        digit_acc = digit_acc * 16'd10 + {8'd0, c - CH_ZERO};
      else
        conv_phase = PH_STOPPED;
    end
  endfunction

  // silent: the dispatched action was already queued from the table
  function automatic void parse_rx_byte(logic [7:0] c, bit silent);
    if (c == CH_TERM) begin
      if (rx_count > 0) commit_field();
      if (frame_overflow) overflow_frames++;
      if (!frame_overflow && !silent) begin
        case (field_vals[0])
          CMD_OFF:   due(ACT_OFF, 5'd0, 16'd0, 1'b0);
          CMD_ON:    due(ACT_ON, 5'd0, 16'd0, 1'b0);
          CMD_STORE: begin
            for (int k = 1; k < FLD_COUNT && k <= STORE_MAX; k++)
              due(ACT_STORE, 5'(2 * k), field_vals[k], 1'b0);
            due(ACT_STORE, 5'd0, STORE_MARKER, 1'b0);
            due(ACT_RESET, 5'd0, 16'd0, 1'b0);
          end
          CMD_SETPT: due(ACT_SETPT, 5'd0, field_vals[1], 1'b0);
          default:   due(ACT_UNKNOWN, 5'd0, 16'd0, 1'b0);
        endcase
      end
      due(ACT_DONE, 5'd0, 16'd0, 1'b1);
      frames_done++;
      clear_frame();
      return;
    end
    if (rx_count >= FRM_BYTES - 1) begin
      frame_overflow = 1'b1;
      return;
    end
    rx_count++;
    if (rx_count == 1) return;
    if (c == CH_COMMA) begin
      commit_field();
      if (field_idx < FLD_COUNT) field_idx++;
      field_chars = 0;
      conv_phase  = PH_BLANKS;
      minus_seen  = 1'b0;
      digit_acc   = 16'd0;
    end else begin
      convert_char(c);
    end
  endfunction

  // ----------------------------------------------------------- frame builder

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_TERM || b == CH_COMMA);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    int pick;
    pick = $urandom_range(0, 5);
    return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
  endfunction

  // random field text: numbers with blanks and signs, long runs, junk
  function automatic void put_field();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: ;
      1, 2, 3: begin
        if ($urandom_range(0, 2) == 0) frame_bytes.push_back(blank_byte());
        if ($urandom_range(0, 2) == 0)
          frame_bytes.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        put_text($sformatf("%0d", $urandom_range(0, 999)));
      end
      4: repeat ($urandom_range(5, 12))
        frame_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      5: case ($urandom_range(0, 3))
        0: put_text("32767");
        1: put_text("-32768");
        2: put_text("65535");
        default: put_text("-1");
      endcase
      6: begin
        put_text($sformatf("%0d", $urandom_range(0, 99)));
        frame_bytes.push_back(plain_byte());
      end
      7: begin
        frame_bytes.push_back(plain_byte());
        put_text($sformatf("%0d", $urandom_range(0, 99)));
      end
      8: repeat ($urandom_range(1, 3)) frame_bytes.push_back(plain_byte());
      default: case ($urandom_range(0, 2))
        0: put_text("-");
        1: put_text("+-5");
        default: put_text(" \t-7x");
      endcase
    endcase
  endfunction

  function automatic void build_frame();
    int r;
    int sel;
    int nf;
    logic [7:0] b;
    frame_bytes.delete();
    r = $urandom_range(0, 19);
    if (r == 0) begin
      // noise, any byte value, terminator only sometimes
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) frame_bytes.push_back(CH_TERM);
    end else if (r == 1) begin
      // over-long frame
      frame_bytes.push_back(plain_byte());
      put_text("4,");
      repeat ($urandom_range(48, 60)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_TERM);
        frame_bytes.push_back(b);
      end
      frame_bytes.push_back(CH_TERM);
    end else if (r == 2) begin
      // store with more commas than fields
      frame_bytes.push_back(plain_byte());
      put_text("3");
      repeat ($urandom_range(13, 16)) begin
        frame_bytes.push_back(CH_COMMA);
        frame_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      frame_bytes.push_back(CH_TERM);
    end else begin
      // well-formed command frame with random field content
      frame_bytes.push_back($urandom_range(0, 7) == 0 ? CH_COMMA : plain_byte());
      sel = $urandom_range(0, 9);
      case (sel)
        0: put_text("1");
        1: put_text("2");
        2, 3, 4: put_text("3");
        5, 6: put_text("4");
        7: put_text(" +4");
        8: put_text("03");
        default: put_field();
      endcase
      nf = (sel >= 2 && sel <= 4) ? $urandom_range(8, 12) : $urandom_range(0, 3);
      repeat (nf) begin
        frame_bytes.push_back(CH_COMMA);
        put_field();
      end
      // a few frames run on into the next one
      if ($urandom_range(0, 9) != 0) frame_bytes.push_back(CH_TERM);
    end
  endfunction

  // ------------------------------------------------------------------ sender

  task automatic send_byte(logic [7:0] c, bit typed, action_t t_act, logic [15:0] t_val);
    int gap;
    gap = (!quiet && tx_gappy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (typed && c == CH_TERM) begin
      if (t_act != ACT_DONE) due(t_act, 5'd0, t_val, 1'b0);
      parse_rx_byte(c, 1'b1);
    end else begin
      parse_rx_byte(c, 1'b0);
    end
  endtask

  // hold the sender until every queued action beat has come out
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (actions_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    int rand_start;
    clear_frame();
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed frames
    foreach (dir_rows[r])
      for (int i = 0; i < dir_rows[r].txt.len(); i++)
        send_byte(dir_rows[r].txt[i], dir_rows[r].typed, dir_rows[r].act, dir_rows[r].val);
    drain();

    // random frames
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RAND_BYTES) begin
      build_frame();
      tx_gappy = ($urandom_range(0, 2) != 0);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, ACT_DONE, 16'd0);
      if (bytes_sent - rand_start >= QUIET_AT) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 24) == 0) drain();
    end

    // wind down
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d bytes, %0d frames (%0d over-long)", bytes_sent, frames_done,
             overflow_frames);
    $display("checked %0d action beats, %0d of them store words", beats_seen, stores_seen);
    if (errors == 0) begin
      $display("[serial_command_frame_parser_core] OK");
    end else begin
      $display("[serial_command_frame_parser_core] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // stall bursts, with calm stretches in between
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) rx_gappy <= !rx_gappy;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && rx_gappy && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare each action beat with the oldest expectation
  always @(posedge clk) begin : check_beat
    action_rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (actions_due.size() == 0) begin
        $error("unexpected action beat: action %0d, store_address %0d, data_value %0d",
               out_tuser, out_tdata[4:0], $signed(out_tdata[20:5]));
        errors++;
      end else begin
        e = actions_due.pop_front();
        if (e.act == ACT_STORE) stores_seen++;
        if (out_tuser != e.act) begin
          $error("action: expected %0d, got %0d", e.act, out_tuser);
          errors++;
        end
        if (out_tdata[4:0] != e.addr) begin
          $error("store_address: expected %0d, got %0d", e.addr, out_tdata[4:0]);
          errors++;
        end
        if (out_tdata[20:5] != e.data) begin
          $error("data_value: expected %0d, got %0d", $signed(e.data),
                 $signed(out_tdata[20:5]));
          errors++;
        end
        if (out_tlast != e.last) begin
          $error("last_of_run: expected %0d, got %0d", e.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("timeout with %0d action beats outstanding", actions_due.size());
      $display("[serial_command_frame_parser_core] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
